// ===== rtl/erm_pkg.sv =====
`timescale 1ns / 1ps

package erm_pkg;

  // Default widths of the angle fields and of the fraction of the result.
  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 14;

  // Register stages of the sine/cosine unit.
  localparam int unsigned SC_STAGES = 18;

  // Q30 constants.
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] Q30_HALF    = 31'h2000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // Signed Q30 value, magnitude at most 1.0.
  typedef logic signed [31:0] q30_t;

endpackage

// ===== rtl/erm_if.sv =====
`timescale 1ns / 1ps

// Angle word channel.
interface erm_in_if #(
  parameter int unsigned ANGLE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] angle_x;
  logic [ANGLE_BITS-1:0] angle_y;
  logic [ANGLE_BITS-1:0] angle_z;

  modport source (output valid, output angle_x, output angle_y, output angle_z, input ready);
  modport sink   (input valid, input angle_x, input angle_y, input angle_z, output ready);
endinterface

// Matrix word channel.
interface erm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m00;
  logic signed [15:0] m01;
  logic signed [15:0] m02;
  logic signed [15:0] m10;
  logic signed [15:0] m11;
  logic signed [15:0] m12;
  logic signed [15:0] m20;
  logic signed [15:0] m21;
  logic signed [15:0] m22;

  modport source (output valid, output m00, output m01, output m02, output m10, output m11,
                  output m12, output m20, output m21, output m22, input ready);
  modport sink   (input valid, input m00, input m01, input m02, input m10, input m11,
                  input m12, input m20, input m21, input m22, output ready);
endinterface

// ===== rtl/erm_sincos.sv =====
`timescale 1ns / 1ps

module erm_sincos import erm_pkg::*; #(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic [SC_STAGES-1:0]  en_i,
  input  logic [ANGLE_BITS-1:0] angle_i,
  output q30_t                  sin_o,
  output q30_t                  cos_o
);

  localparam int unsigned PAD   = 32 - ANGLE_BITS;
  localparam int unsigned ITERS = 5;

  // Quadrant numbers.
  localparam logic [1:0] QUAD_FIRST  = 2'd0;
  localparam logic [1:0] QUAD_SECOND = 2'd1;
  localparam logic [1:0] QUAD_THIRD  = 2'd2;
  localparam logic [1:0] QUAD_FOURTH = 2'd3;

  // Horner divisors and their Q30 reciprocals; row 0 is sine, row 1 cosine.
  localparam int unsigned DIV [2][ITERS] = '{'{110, 72, 42, 20, 6}, '{90, 56, 30, 12, 2}};
  localparam int unsigned RECIP [2][ITERS] = '{
    '{9761289, 14913080, 25565281, 53687091, 178956970},
    '{11930464, 19173961, 35791394, 89478485, 536870912}
  };

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] x2;
    logic [1:0]  quad;
    logic        mir;
  } sc_meta_t;

  logic [31:0] phase;
  logic [29:0] ofs;
  logic [30:0] ofs_diff;
  logic        mirror;
  logic [29:0] ofs_m;
  logic [60:0] x_prod;
  logic [59:0] x2_prod;
  sc_meta_t    meta1_d;
  sc_meta_t    meta_q [SC_STAGES-1];

  logic [30:0] t_q [ITERS][2];

  // Reduce the angle to the first eighth turn.
  assign phase    = {angle_i, {PAD{1'b0}}};
  assign ofs      = phase[29:0];
  assign ofs_diff = Q30_ONE - {1'b0, ofs};
  assign mirror   = {1'b0, ofs} > Q30_HALF;
  assign ofs_m    = mirror ? ofs_diff[29:0] : ofs;
  assign x_prod   = 61'(ofs_m) * 61'(HALF_PI_Q30) + 61'(Q30_HALF);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      meta_q[0] <= '{x: x_prod[59:30], x2: '0, quad: phase[31:30], mir: mirror};
    end
  end

  // Square of the reduced angle.
  assign x2_prod = 60'(meta_q[0].x) * 60'(meta_q[0].x);

  always_comb begin
    meta1_d    = meta_q[0];
    meta1_d.x2 = x2_prod[59:30];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      meta_q[1] <= meta1_d;
    end
  end

  // Angle, square and quadrant travel alongside the series.
  for (genvar k = 2; k < SC_STAGES - 1; k++) begin : g_meta
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  // Horner steps: product, reciprocal product, then correction and subtract.
  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    for (genvar j = 0; j < 2; j++) begin : g_fn
      localparam int unsigned B = 2 + 3 * i;

      logic [30:0] t_in;
      logic [60:0] p_prod;
      logic [29:0] p_q;
      logic [59:0] r_prod;
      logic [29:0] pp_q;
      logic [29:0] q0_q;
      logic [36:0] qd;
      logic [36:0] rem;
      logic [30:0] quo;

      if (i == 0) begin : g_first
        assign t_in = Q30_ONE;
      end else begin : g_next
        assign t_in = t_q[i-1][j];
      end

      assign p_prod = 61'(meta_q[B-1].x2) * 61'(t_in);

      always_ff @(posedge clk_i) begin
        if (en_i[B]) begin
          p_q <= p_prod[59:30];
        end
      end

      assign r_prod = 60'(p_q) * 60'(RECIP[j][i]);

      always_ff @(posedge clk_i) begin
        if (en_i[B+1]) begin
          pp_q <= p_q;
          q0_q <= r_prod[59:30];
        end
      end

      // The estimate is the quotient or one below it.
      assign qd  = 37'(q0_q) * 37'(DIV[j][i]);
      assign rem = 37'(pp_q) - qd;
      assign quo = 31'(q0_q) + 31'(rem >= 37'(DIV[j][i]));

      always_ff @(posedge clk_i) begin
        if (en_i[B+2]) begin
          t_q[i][j] <= Q30_ONE - quo;
        end
      end
    end
  end

  // Final sine product, undo the mirror and apply the quadrant signs.
  logic [60:0] s_prod;
  q30_t        s_v;
  q30_t        c_v;
  q30_t        s_sw;
  q30_t        c_sw;
  q30_t        sin_d;
  q30_t        cos_d;

  assign s_prod = 61'(meta_q[SC_STAGES-2].x) * 61'(t_q[ITERS-1][0]);
  assign s_v    = q30_t'({2'b00, s_prod[59:30]});
  assign c_v    = q30_t'({1'b0, t_q[ITERS-1][1]});
  assign s_sw   = meta_q[SC_STAGES-2].mir ? c_v : s_v;
  assign c_sw   = meta_q[SC_STAGES-2].mir ? s_v : c_v;

  always_comb begin
    unique case (meta_q[SC_STAGES-2].quad)
      QUAD_FIRST: begin
        sin_d = s_sw;
        cos_d = c_sw;
      end
      QUAD_SECOND: begin
        sin_d = c_sw;
        cos_d = -s_sw;
      end
      QUAD_THIRD: begin
        sin_d = -s_sw;
        cos_d = -c_sw;
      end
      QUAD_FOURTH: begin
        sin_d = -c_sw;
        cos_d = s_sw;
      end
      default: begin
        sin_d = s_sw;
        cos_d = c_sw;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[SC_STAGES-1]) begin
      sin_o <= sin_d;
      cos_o <= cos_d;
    end
  end

endmodule

// ===== rtl/euler_xyz_rotation_matrix.sv =====
`timescale 1ns / 1ps
// Throughput: one word per cycle while out_if.ready does not stall the pipeline; 18 stages
// of sine/cosine series, two product stages, one sum stage and one rounding stage form
// a single pipeline.
// Each stage holds a valid bit and takes a new word whenever it is empty or moves on.
// Reset (rst_ni low, asynchronous) clears all valid bits; the data registers keep no reset.
module euler_xyz_rotation_matrix import erm_pkg::*; #(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  erm_in_if.sink  in_if,
  erm_out_if.source out_if
);

  localparam int unsigned NSTG = SC_STAGES + 4;
  localparam int unsigned SP1  = SC_STAGES;
  localparam int unsigned SP2  = SC_STAGES + 1;
  localparam int unsigned SSUM = SC_STAGES + 2;
  localparam int unsigned SOUT = SC_STAGES + 3;
  localparam int unsigned SH   = 30 - FRAC_BITS;
  localparam logic [33:0] RND  = (SH > 0) ? (34'(1) << (SH - 1)) : 34'(0);
  localparam logic [33:0] LIM  = 34'(1) << FRAC_BITS;

  // Product of two Q30 values, rounded on the magnitude.
  function automatic q30_t mul_q30(q30_t a, q30_t b);
    logic        neg;
    logic [30:0] ma;
    logic [30:0] mb;
    logic [61:0] pr;
    q30_t        m;
    neg = a[31] ^ b[31];
    ma  = a[31] ? 31'(-a) : 31'(a);
    mb  = b[31] ? 31'(-b) : 31'(b);
    pr  = 62'(ma) * 62'(mb) + 62'(Q30_HALF);
    m   = q30_t'({1'b0, pr[60:30]});
    return neg ? -m : m;
  endfunction

  // Round a Q30 sum to the output fraction and saturate at one.
  function automatic logic [15:0] to_field(logic signed [32:0] v);
    logic        neg;
    logic [33:0] mag;
    logic [33:0] res;
    neg = v[32];
    mag = neg ? 34'(-v) : 34'(v);
    mag = (mag + RND) >> SH;
    if (mag > LIM) begin
      mag = LIM;
    end
    res = neg ? -mag : mag;
    return res[15:0];
  endfunction

  // Valid chain; a stage loads when it is empty or its successor moves.
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] vld_in;
  logic [NSTG:0]   rdy;

  assign rdy[NSTG] = out_if.ready;
  assign vld_in    = {vld_q[NSTG-2:0], in_if.valid};

  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = ~vld_q[k] | rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  assign in_if.ready  = rdy[0];
  assign out_if.valid = vld_q[NSTG-1];

  // Sines and cosines of the three angles.
  q30_t sa, ca, sb, cb, sc, cc;

  erm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_x (
    .clk_i  (clk_i),
    .en_i   (rdy[SC_STAGES-1:0]),
    .angle_i(in_if.angle_x),
    .sin_o  (sa),
    .cos_o  (ca)
  );

  erm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_y (
    .clk_i  (clk_i),
    .en_i   (rdy[SC_STAGES-1:0]),
    .angle_i(in_if.angle_y),
    .sin_o  (sb),
    .cos_o  (cb)
  );

  erm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc_z (
    .clk_i  (clk_i),
    .en_i   (rdy[SC_STAGES-1:0]),
    .angle_i(in_if.angle_z),
    .sin_o  (sc),
    .cos_o  (cc)
  );

  // First products; sb, sc and cc move along with them.
  q30_t sasb_q, casb_q, cbcc_q, cbsc_q, casc_q, cacc_q, sacb_q, sasc_q, sacc_q, cacb_q;
  q30_t sb_q, sc_q, cc_q;

  always_ff @(posedge clk_i) begin
    if (rdy[SP1]) begin
      sasb_q <= mul_q30(sa, sb);
      casb_q <= mul_q30(ca, sb);
      cbcc_q <= mul_q30(cb, cc);
      cbsc_q <= mul_q30(cb, sc);
      casc_q <= mul_q30(ca, sc);
      cacc_q <= mul_q30(ca, cc);
      sacb_q <= mul_q30(sa, cb);
      sasc_q <= mul_q30(sa, sc);
      sacc_q <= mul_q30(sa, cc);
      cacb_q <= mul_q30(ca, cb);
      sb_q   <= sb;
      sc_q   <= sc;
      cc_q   <= cc;
    end
  end

  // Three-factor products; the two-factor products and sb move along with them.
  q30_t t10_q, t11_q, t20_q, t21_q;
  q30_t p00_q, p01_q, p02_q, p10_q, p11_q, p12_q, p20_q, p21_q, p22_q;

  always_ff @(posedge clk_i) begin
    if (rdy[SP2]) begin
      t10_q <= mul_q30(sasb_q, cc_q);
      t11_q <= mul_q30(sasb_q, sc_q);
      t20_q <= mul_q30(casb_q, cc_q);
      t21_q <= mul_q30(casb_q, sc_q);
      p00_q <= cbcc_q;
      p01_q <= cbsc_q;
      p02_q <= sb_q;
      p10_q <= casc_q;
      p11_q <= cacc_q;
      p12_q <= sacb_q;
      p20_q <= sasc_q;
      p21_q <= sacc_q;
      p22_q <= cacb_q;
    end
  end

  // Entry sums in Q30.
  logic signed [32:0] e00_q, e01_q, e02_q, e10_q, e11_q, e12_q, e20_q, e21_q, e22_q;

  always_ff @(posedge clk_i) begin
    if (rdy[SSUM]) begin
      e00_q <= 33'(p00_q);
      e01_q <= -33'(p01_q);
      e02_q <= 33'(p02_q);
      e10_q <= 33'(t10_q) + 33'(p10_q);
      e11_q <= 33'(p11_q) - 33'(t11_q);
      e12_q <= -33'(p12_q);
      e20_q <= 33'(p20_q) - 33'(t20_q);
      e21_q <= 33'(t21_q) + 33'(p21_q);
      e22_q <= 33'(p22_q);
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (rdy[SOUT]) begin
      out_if.m00 <= to_field(e00_q);
      out_if.m01 <= to_field(e01_q);
      out_if.m02 <= to_field(e02_q);
      out_if.m10 <= to_field(e10_q);
      out_if.m11 <= to_field(e11_q);
      out_if.m12 <= to_field(e12_q);
      out_if.m20 <= to_field(e20_q);
      out_if.m21 <= to_field(e21_q);
      out_if.m22 <= to_field(e22_q);
    end
  end

endmodule

// ===== rtl/erm_checker.sv =====
`timescale 1ns / 1ps

module erm_checker import erm_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [15:0] m00_i,
  input logic signed [15:0] m01_i,
  input logic signed [15:0] m02_i,
  input logic signed [15:0] m10_i,
  input logic signed [15:0] m11_i,
  input logic signed [15:0] m12_i,
  input logic signed [15:0] m20_i,
  input logic signed [15:0] m21_i,
  input logic signed [15:0] m22_i
);

  localparam int LIM = (FRAC_BITS > 14) ? 0 : (1 << FRAC_BITS);

  logic [143:0] word;
  logic         in_range;

  assign word = {m00_i, m01_i, m02_i, m10_i, m11_i, m12_i, m20_i, m21_i, m22_i};

  // Every entry lies within plus or minus one when the fraction fits the field.
  always_comb begin
    in_range = 1'b1;
    for (int k = 0; k < 9; k++) begin
      if ((FRAC_BITS <= 14) &&
          (($signed(word[k*16 +: 16]) > LIM) || ($signed(word[k*16 +: 16]) < -LIM))) begin
        in_range = 1'b0;
      end
    end
  end

  // No word is offered while reset is held.
  a_no_valid_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("matrix word offered during reset");

  // A stalled word stays offered.
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("matrix word withdrawn while stalled");

  // A stalled word keeps its entries.
  a_word_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(word))
    else $error("matrix word changed while stalled");

  // Entries are saturated to one.
  a_entry_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> in_range)
    else $error("matrix entry beyond one");

endmodule

bind euler_xyz_rotation_matrix erm_checker #(.FRAC_BITS(FRAC_BITS)) u_erm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready),
  .m00_i      (out_if.m00),
  .m01_i      (out_if.m01),
  .m02_i      (out_if.m02),
  .m10_i      (out_if.m10),
  .m11_i      (out_if.m11),
  .m12_i      (out_if.m12),
  .m20_i      (out_if.m20),
  .m21_i      (out_if.m21),
  .m22_i      (out_if.m22)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import erm_pkg::*;

  localparam int unsigned ANG_W     = 16;
  localparam int unsigned FRAC_W    = 14;
  localparam int unsigned LATENCY   = 22;
  localparam longint unsigned ONE30 = 64'd1 << 30;
  localparam longint unsigned HPI30 = 64'd1686629713;
  localparam int unsigned CYCLE_CAP = 400000;
  localparam int unsigned N_RANDOM  = 1300;

  typedef struct packed {
    logic [ANG_W-1:0] ax;
    logic [ANG_W-1:0] ay;
    logic [ANG_W-1:0] az;
  } angles_t;

  typedef struct packed {
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } matrix_t;

  logic clk_i;
  logic rst_ni;

  erm_in_if #(.ANGLE_BITS(ANG_W)) in_if ();
  erm_out_if out_if ();

  euler_xyz_rotation_matrix #(.ANGLE_BITS(ANG_W), .FRAC_BITS(FRAC_W)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  angles_t pending_angles[$];
  matrix_t expected_matrices[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_cycles;
  int unsigned cycle_count;
  int unsigned fail_count;
  bit in_acc_q;

  // Clock.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sine and cosine in Q30 for one angle, using the series of the block.
  task automatic sine_cosine(input logic [ANG_W-1:0] ang, output longint s_o,
                             output longint c_o);
    longint unsigned ph, r, x, x2, ts, tc, s, c, tmp;
    longint unsigned sdiv[5];
    longint unsigned cdiv[5];
    int unsigned quad;
    bit mirror;
    sdiv = '{110, 72, 42, 20, 6};
    cdiv = '{90, 56, 30, 12, 2};
    ph = (64'(ang) << (32 - ANG_W)) & 64'hFFFF_FFFF;
    quad = int'((ph >> 30) & 3);
    r = ph & (ONE30 - 1);
    mirror = r > (ONE30 >> 1);
    if (mirror) r = ONE30 - r;
    x = (r * HPI30 + (ONE30 >> 1)) >> 30;
    x2 = (x * x) >> 30;
    ts = ONE30;
    tc = ONE30;
    for (int i = 0; i < 5; i++) begin
      ts = ONE30 - ((x2 * ts) >> 30) / sdiv[i];
      tc = ONE30 - ((x2 * tc) >> 30) / cdiv[i];
    end
    s = (x * ts) >> 30;
    c = tc;
    if (mirror) begin
      tmp = s;
      s = c;
      c = tmp;
    end
    case (quad)
      0: begin s_o = longint'(s); c_o = longint'(c); end
      1: begin s_o = longint'(c); c_o = -longint'(s); end
      2: begin s_o = -longint'(s); c_o = -longint'(c); end
      default: begin s_o = -longint'(c); c_o = longint'(s); end
    endcase
  endtask

  // Q30 product rounded on the magnitude, half away from zero.
  function automatic longint q30_product(longint a, longint b);
    longint unsigned ma, mb, m;
    ma = (a < 0) ? longint'(-a) : a;
    mb = (b < 0) ? longint'(-b) : b;
    m = (ma * mb + (ONE30 >> 1)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  // Round Q30 to the entry format and saturate to plus or minus one.
  function automatic logic signed [15:0] to_entry(longint v);
    longint unsigned m, lim;
    longint r;
    m = (v < 0) ? longint'(-v) : v;
    lim = 64'd1 << FRAC_W;
    m = (m + (64'd1 << (29 - FRAC_W))) >> (30 - FRAC_W);
    if (m > lim) m = lim;
    r = (v < 0) ? -longint'(m) : longint'(m);
    return r[15:0];
  endfunction

  task automatic rotation_matrix(input angles_t a, output matrix_t m);
    longint sa, ca, sb, cb, sc, cc, sasb, casb;
    sine_cosine(a.ax, sa, ca);
    sine_cosine(a.ay, sb, cb);
    sine_cosine(a.az, sc, cc);
    sasb = q30_product(sa, sb);
    casb = q30_product(ca, sb);
    m.m00 = to_entry(q30_product(cb, cc));
    m.m01 = to_entry(-q30_product(cb, sc));
    m.m02 = to_entry(sb);
    m.m10 = to_entry(q30_product(sasb, cc) + q30_product(ca, sc));
    m.m11 = to_entry(-q30_product(sasb, sc) + q30_product(ca, cc));
    m.m12 = to_entry(-q30_product(sa, cb));
    m.m20 = to_entry(-q30_product(casb, cc) + q30_product(sa, sc));
    m.m21 = to_entry(q30_product(casb, sc) + q30_product(sa, cc));
    m.m22 = to_entry(q30_product(ca, cb));
  endtask

  task automatic check_entry(string name, logic signed [15:0] exp_v,
                             logic signed [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Acceptance of the offered word, taken at the rising edge.
  always @(posedge clk_i) begin
    in_acc_q <= rst_ni && in_if.valid && in_if.ready;
  end

  // Driver: offers words from the pending queue, changing at the falling edge.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_acc_q) begin
        angles_t sent;
        matrix_t m;
        sent = pending_angles.pop_front();
        rotation_matrix(sent, m);
        expected_matrices.push_back(m);
      end
      if (in_if.valid && !in_acc_q) begin
        // An offered word stays put until it is taken.
        in_if.valid <= 1'b1;
      end else if (pending_angles.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_if.valid   <= 1'b1;
        in_if.angle_x <= pending_angles[0].ax;
        in_if.angle_y <= pending_angles[0].ay;
        in_if.angle_z <= pending_angles[0].az;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, with an optional long hold-off.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles  <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compares each matrix word with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_matrices.size() == 0) begin
        $error("matrix word with no expectation pending");
        fail_count++;
      end else begin
        matrix_t e;
        e = expected_matrices.pop_front();
        check_entry("m00", e.m00, out_if.m00);
        check_entry("m01", e.m01, out_if.m01);
        check_entry("m02", e.m02, out_if.m02);
        check_entry("m10", e.m10, out_if.m10);
        check_entry("m11", e.m11, out_if.m11);
        check_entry("m12", e.m12, out_if.m12);
        check_entry("m20", e.m20, out_if.m20);
        check_entry("m21", e.m21, out_if.m21);
        check_entry("m22", e.m22, out_if.m22);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("euler_xyz_rotation_matrix: mismatch");
      $finish;
    end
  end

  function automatic logic [ANG_W-1:0] random_angle();
    case ($urandom_range(3))
      0: return ANG_W'($urandom_range(3) << (ANG_W - 2)) + ANG_W'($urandom_range(2))
                - ANG_W'(1);
      1: return ANG_W'($urandom_range(3) << (ANG_W - 3));
      default: return ANG_W'($urandom());
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_angles.size() > 0 || in_if.valid || expected_matrices.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic queue_random(int unsigned count);
    angles_t a;
    for (int unsigned i = 0; i < count; i++) begin
      a.ax = random_angle();
      a.ay = random_angle();
      a.az = random_angle();
      pending_angles.push_back(a);
    end
  endtask

  initial begin
    logic [ANG_W-1:0] corners[12];
    angles_t a;
    corners = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h2000,
                16'h2001, 16'h1FFF, 16'h3FFF, 16'h4001, 16'h6000, 16'hA000};
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.angle_x = '0;
    in_if.angle_y = '0;
    in_if.angle_z = '0;
    out_if.ready = 1'b0;
    send_idle_pct = 15;
    recv_idle_pct = 88;
    hold_cycles = 0;
    cycle_count = 0;
    fail_count = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: quadrant edges, the eighth-turn mirror point and field extremes.
    for (int i = 0; i < 12; i++) begin
      a.ax = corners[i];
      a.ay = corners[(i + 3) % 12];
      a.az = corners[(i + 7) % 12];
      pending_angles.push_back(a);
    end
    a = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
    pending_angles.push_back(a);
    a = '{16'h5555, 16'hAAAA, 16'h5555};
    pending_angles.push_back(a);
    wait_drained();

    // Sender pauses until everything is back, then a long receiver hold-off.
    queue_random(N_RANDOM / 3);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 200;
    queue_random(80);
    wait_drained();

    send_idle_pct = 88;
    recv_idle_pct = 15;
    queue_random(N_RANDOM / 3);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(N_RANDOM / 3);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);

    if (fail_count == 0 && expected_matrices.size() == 0) begin
      $display("euler_xyz_rotation_matrix: match");
    end else begin
      $display("euler_xyz_rotation_matrix: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/erm_pkg.sv
rtl/erm_if.sv
rtl/erm_sincos.sv
rtl/euler_xyz_rotation_matrix.sv
rtl/erm_checker.sv
tb/sv/testbench.sv
